### rtl/bms_pkg.sv
`timescale 1ns / 1ps
// Package for the block-matching SAD search block.
// Holds lane count, widths, saturation limits and the item struct types.
// No dependencies.
package bms_pkg;

	// Lane and width constants
	localparam int LANES      = 8;
	localparam int PIX_W      = 8;
	localparam int TAG_W      = 4;
	localparam int GSUM_W     = $clog2(LANES * ((1 << PIX_W) - 1) + 1);
	localparam int SUM_W      = 21;
	localparam int SAD_W      = 20;
	localparam int BLK_PIXELS = 64;
	localparam int SEARCH_RADIUS = 4;
	localparam int OFFSET_LIMIT  = SEARCH_RADIUS;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [SAD_W-1:0] SAD_MAX = {SAD_W{1'b1}};

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [LANES-1:0][PIX_W-1:0] lane_diff_t;

	// One input transfer: a group of pixel pairs plus candidate tag
	typedef struct packed {
		logic [63:0]             ref_pixels;
		logic [63:0]             cur_pixels;
		logic signed [TAG_W-1:0] cand_dx;
		logic signed [TAG_W-1:0] cand_dy;
		logic signed [TAG_W-1:0] cand_angle;
		logic                    last_of_candidate;
		logic                    last_of_search;
	} item_t;

	// Candidate tag carried down the pipeline
	typedef struct packed {
		logic signed [TAG_W-1:0] dx;
		logic signed [TAG_W-1:0] dy;
		logic signed [TAG_W-1:0] angle;
		logic                    last_cand;
		logic                    last_search;
	} tag_t;

	// One result transfer
	typedef struct packed {
		logic signed [TAG_W-1:0] best_dx;
		logic signed [TAG_W-1:0] best_dy;
		logic signed [TAG_W-1:0] best_angle;
		logic [SAD_W-1:0]        best_sad;
	} result_t;

endpackage

### rtl/bms_lane.sv
`timescale 1ns / 1ps
// One SAD lane: registered absolute difference of one pixel pair.
// Depends on bms_pkg.
module bms_lane (
	input  logic          clk,
	input  logic          en,
	input  bms_pkg::pix_t pix_a,
	input  bms_pkg::pix_t pix_b,
	output bms_pkg::pix_t diff_s1
);

	bms_pkg::pix_t diff;

	// |a - b| on unsigned bytes
	always_comb begin
		if (pix_a > pix_b) begin
			diff = pix_a - pix_b;
		end else begin
			diff = pix_b - pix_a;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= diff;
		end
	end

endmodule

### rtl/bms_accum.sv
`timescale 1ns / 1ps
// Merge stage: adds the lane differences, accumulates the candidate sum,
// tracks the best candidate and holds the result register. Depends on bms_pkg.
module bms_accum (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  bms_pkg::tag_t       tag_s1,
	input  bms_pkg::lane_diff_t diff_s1,
	input  logic                result_stall,
	output logic                en,
	output logic                result_valid,
	output bms_pkg::result_t    result
);

	logic [bms_pkg::GSUM_W-1:0] gsum;
	logic [bms_pkg::GSUM_W-1:0] gsum_s2;
	bms_pkg::tag_t              tag_s2;
	logic                       valid_s2;

	logic [bms_pkg::SUM_W-1:0]  running_sum_q;
	logic [bms_pkg::SUM_W-1:0]  best_sum_q;
	logic signed [bms_pkg::TAG_W-1:0] best_dx_q;
	logic signed [bms_pkg::TAG_W-1:0] best_dy_q;
	logic signed [bms_pkg::TAG_W-1:0] best_angle_q;
	logic                       first_pending_q;

	logic                       hold;
	logic                       fire;
	logic [bms_pkg::SUM_W:0]    sum_wide;
	logic [bms_pkg::SUM_W-1:0]  sum_next;
	logic                       take;
	logic [bms_pkg::SUM_W-1:0]  new_best;
	logic signed [bms_pkg::TAG_W-1:0] new_dx;
	logic signed [bms_pkg::TAG_W-1:0] new_dy;
	logic signed [bms_pkg::TAG_W-1:0] new_angle;

	// Adder tree over the lanes
	always_comb begin
		gsum = '0;
		for (int i = 0; i < bms_pkg::LANES; i++) begin
			gsum = gsum + bms_pkg::GSUM_W'(diff_s1[i]);
		end
	end

	// Pipeline stalls only when a search-closing group meets a full output
	assign hold = valid_s2 && tag_s2.last_cand && tag_s2.last_search
		&& result_valid && result_stall;
	assign en   = !hold;
	assign fire = valid_s2 && !hold;

	// Saturating accumulate and best compare
	assign sum_wide = {1'b0, running_sum_q} + (bms_pkg::SUM_W + 1)'(gsum_s2);
	assign sum_next = sum_wide[bms_pkg::SUM_W] ? bms_pkg::SUM_MAX
		: sum_wide[bms_pkg::SUM_W-1:0];
	assign take     = first_pending_q || (sum_next < best_sum_q);
	assign new_best  = take ? sum_next     : best_sum_q;
	assign new_dx    = take ? tag_s2.dx    : best_dx_q;
	assign new_dy    = take ? tag_s2.dy    : best_dy_q;
	assign new_angle = take ? tag_s2.angle : best_angle_q;

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			gsum_s2 <= gsum;
			tag_s2  <= tag_s1;
		end
	end

	// Candidate state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2        <= 1'b0;
			running_sum_q   <= '0;
			best_sum_q      <= '0;
			best_dx_q       <= '0;
			best_dy_q       <= '0;
			best_angle_q    <= '0;
			first_pending_q <= 1'b1;
			result_valid    <= 1'b0;
			result          <= '0;
		end else begin
			if (en) begin
				valid_s2 <= valid_s1;
			end
			if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end
			if (fire) begin
				if (!tag_s2.last_cand) begin
					running_sum_q <= sum_next;
				end else begin
					running_sum_q <= '0;
					best_sum_q    <= new_best;
					best_dx_q     <= new_dx;
					best_dy_q     <= new_dy;
					best_angle_q  <= new_angle;
					if (tag_s2.last_search) begin
						first_pending_q    <= 1'b1;
						result_valid       <= 1'b1;
						result.best_dx     <= new_dx;
						result.best_dy     <= new_dy;
						result.best_angle  <= new_angle;
						result.best_sad    <= (new_best > bms_pkg::SUM_W'(bms_pkg::SAD_MAX))
							? bms_pkg::SAD_MAX : new_best[bms_pkg::SAD_W-1:0];
					end else begin
						first_pending_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

### rtl/block_match_sad_search.sv
`timescale 1ns / 1ps
// Full-search block matcher by sum of absolute differences. Each transfer
// carries eight pixel pairs that go through eight difference lanes, an adder
// tree and a saturating accumulator; one transfer is taken every cycle unless
// the input stalls, and a search's result is registered after its closing
// transfer passes stage 1 and stage 2. The input stalls only when a group
// closing a search reaches the accumulator while the previous result still
// waits in the output register. Ties keep the earlier candidate; the tag is
// taken from the group closing each candidate. Depends on bms_pkg, bms_lane and bms_accum.
module block_match_sad_search (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  bms_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output bms_pkg::result_t result
);

	logic                en;
	logic                valid_s1;
	bms_pkg::tag_t       tag_s1;
	bms_pkg::lane_diff_t diff_s1;

	assign item_stall = !en;

	// Difference lanes
	for (genvar g = 0; g < bms_pkg::LANES; g++) begin : g_lane
		bms_lane u_lane (
			.clk     (clk),
			.en      (en),
			.pix_a   (item.ref_pixels[g*bms_pkg::PIX_W +: bms_pkg::PIX_W]),
			.pix_b   (item.cur_pixels[g*bms_pkg::PIX_W +: bms_pkg::PIX_W]),
			.diff_s1 (diff_s1[g])
		);
	end

	// Stage 1 control and tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && item_valid) begin
			tag_s1.dx          <= item.cand_dx;
			tag_s1.dy          <= item.cand_dy;
			tag_s1.angle       <= item.cand_angle;
			tag_s1.last_cand   <= item.last_of_candidate;
			tag_s1.last_search <= item.last_of_search;
		end
	end

	bms_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.tag_s1       (tag_s1),
		.diff_s1      (diff_s1),
		.result_stall (result_stall),
		.en           (en),
		.result_valid (result_valid),
		.result       (result)
	);

	// The input only backs up behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("input stalled without a blocked result");

	// An accepted transfer occupies stage 1 on the next cycle
	a_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> valid_s1)
		else $error("accepted transfer lost at stage 1");

	// Stage 1 holds its transfer while the pipeline is stalled
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && item_stall) |=> valid_s1)
		else $error("stage 1 transfer dropped during stall");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for block_match_sad_search: directed table, random searches,
// one saturating candidate; predicts each search's best and checks results in order.
// Depends on bms_pkg and the block's RTL.
module tb_top;
	import bms_pkg::*;

	localparam int MAX_CYCLES   = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int IDLE_PCT     = 31;
	localparam int RAND_ITEMS   = 450;
	localparam int QUIET_FROM   = 150;
	localparam int QUIET_TO     = 300;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	block_match_sad_search u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #6 clk = ~clk;

	// Search tracker state, mirrors the block after reset
	logic [SUM_W-1:0]        acc_sum      = '0;
	logic [SUM_W-1:0]        win_sum      = '0;
	logic signed [TAG_W-1:0] win_dx       = '0;
	logic signed [TAG_W-1:0] win_dy       = '0;
	logic signed [TAG_W-1:0] win_ang      = '0;
	bit                      fresh_search = 1'b1;

	result_t best_match_q[$];
	int      errors  = 0;
	int      cycles  = 0;
	int      sent    = 0;
	bit      idle_en = 1'b1;

	typedef struct {
		item_t   it;
		bit      fixed;
		result_t res;
	} dir_row_t;

	dir_row_t dir_rows[$];

	// Sum of absolute differences over the active lanes of one group
	function automatic logic [GSUM_W-1:0] group_abs_sum(input logic [63:0] a,
			input logic [63:0] b);
		logic [GSUM_W-1:0] s;
		logic [PIX_W-1:0]  pa;
		logic [PIX_W-1:0]  pb;
		s = '0;
		for (int i = 0; i < LANES; i++) begin
			pa = a[PIX_W*i +: PIX_W];
			pb = b[PIX_W*i +: PIX_W];
			s += (pa > pb) ? (pa - pb) : (pb - pa);
		end
		return s;
	endfunction

	// Advance the search on one accepted group; returns 1 when a result is due
	function automatic bit match_predict(input item_t it, output result_t r);
		logic [SUM_W:0] t;
		r = '0;
		t = {1'b0, acc_sum} + group_abs_sum(it.ref_pixels, it.cur_pixels);
		acc_sum = (t > SUM_MAX) ? SUM_MAX : t[SUM_W-1:0];
		if (!it.last_of_candidate)
			return 1'b0;
		// strictly smaller wins, ties keep the earlier candidate
		if (fresh_search || acc_sum < win_sum) begin
			win_sum = acc_sum;
			win_dx  = it.cand_dx;
			win_dy  = it.cand_dy;
			win_ang = it.cand_angle;
		end
		acc_sum      = '0;
		fresh_search = 1'b0;
		if (!it.last_of_search)
			return 1'b0;
		r.best_dx    = win_dx;
		r.best_dy    = win_dy;
		r.best_angle = win_ang;
		r.best_sad   = (win_sum > SAD_MAX) ? SAD_MAX : win_sum[SAD_W-1:0];
		fresh_search = 1'b1;
		return 1'b1;
	endfunction

	function automatic item_t mk(input logic [63:0] rp, input logic [63:0] cp,
			input logic [3:0] dx, input logic [3:0] dy, input logic [3:0] ang,
			input bit lc, input bit ls);
		item_t it;
		it.ref_pixels        = rp;
		it.cur_pixels        = cp;
		it.cand_dx           = dx;
		it.cand_dy           = dy;
		it.cand_angle        = ang;
		it.last_of_candidate = lc;
		it.last_of_search    = ls;
		return it;
	endfunction

	function automatic result_t rs(input logic [3:0] dx, input logic [3:0] dy,
			input logic [3:0] ang, input logic [SAD_W-1:0] sad);
		result_t r;
		r.best_dx    = dx;
		r.best_dy    = dy;
		r.best_angle = ang;
		r.best_sad   = sad;
		return r;
	endfunction

	task automatic add_row(input item_t it, input bit fixed, input result_t r);
		dir_row_t row;
		row.it    = it;
		row.fixed = fixed;
		row.res   = r;
		dir_rows.push_back(row);
	endtask

	// Mostly in-range tags, sometimes any 4-bit pattern
	function automatic logic [3:0] rand_tag();
		if ($urandom_range(9) == 0)
			return 4'($urandom_range(15));
		return 4'($urandom_range(8) - 4);
	endfunction

	// Current pixels derived lane by lane from the reference: random, equal, near, inverted
	function automatic logic [63:0] near_pixels(input logic [63:0] base);
		logic [63:0] p;
		p = base;
		for (int i = 0; i < 8; i++) begin
			case ($urandom_range(3))
				0: p[8*i +: 8] = 8'($urandom_range(255));
				1: p[8*i +: 8] = base[8*i +: 8];
				2: p[8*i +: 8] = base[8*i +: 8] ^ 8'($urandom_range(7));
				default: p[8*i +: 8] = ~base[8*i +: 8];
			endcase
		end
		return p;
	endfunction

	// Drive one transfer from a falling edge, hold until accepted, then track it
	task automatic send(input item_t it, input bit fixed, input result_t fixed_res);
		result_t r;
		bit      has;
		while (idle_en && $urandom_range(99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		has = match_predict(it, r);
		if (fixed)
			best_match_q.push_back(fixed_res);
		else if (has)
			best_match_q.push_back(r);
		sent++;
		@(negedge clk);
	endtask

	// One well-formed search with random content and stray search-end marks
	task automatic random_search();
		int          ncand;
		int          ngrp;
		logic [63:0] rp;
		bit          lc;
		bit          ls;
		ncand = $urandom_range(1, 6);
		for (int c = 0; c < ncand; c++) begin
			ngrp = ($urandom_range(15) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
			for (int g = 0; g < ngrp; g++) begin
				rp = {$urandom, $urandom};
				lc = (g == ngrp - 1);
				ls = lc ? (c == ncand - 1) : ($urandom_range(9) == 0);
				send(mk(rp, near_pixels(rp), rand_tag(), rand_tag(), rand_tag(), lc, ls),
					1'b0, '0);
			end
		end
	endtask

	// Single-candidate search of full-swing groups, drives the sums into saturation
	task automatic long_search(input int ngrp);
		bit lc;
		for (int g = 0; g < ngrp; g++) begin
			lc = (g == ngrp - 1);
			if (g[0])
				send(mk('1, '0, rand_tag(), rand_tag(), rand_tag(), lc, lc), 1'b0, '0);
			else
				send(mk('0, '1, rand_tag(), rand_tag(), rand_tag(), lc, lc), 1'b0, '0);
		end
	endtask

	// Result side backpressure
	always @(negedge clk)
		result_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);

	// Result checker
	always @(posedge clk) begin : chk
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (best_match_q.size() == 0) begin
				$display("%0t: unexpected result dx=%0d dy=%0d ang=%0d sad=%0d", $realtime,
					result.best_dx, result.best_dy, result.best_angle, result.best_sad);
				errors++;
			end else begin
				want = best_match_q.pop_front();
				if (result.best_dx !== want.best_dx || result.best_dy !== want.best_dy ||
						result.best_angle !== want.best_angle ||
						result.best_sad !== want.best_sad) begin
					$display("%0t: expected %0d/%0d/%0d sad %0d, got %0d/%0d/%0d sad %0d",
						$realtime, want.best_dx, want.best_dy, want.best_angle, want.best_sad,
						result.best_dx, result.best_dy, result.best_angle, result.best_sad);
					errors++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= MAX_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stim
		int base;

		// full swing one way, then the other, extreme tag patterns
		add_row(mk('1, '0, -4, 4, -4, 1, 1), 1'b1, rs(-4, 4, -4, 2040));
		add_row(mk('0, '1, 7, -8, 7, 1, 1), 1'b1, rs(7, -8, 7, 2040));
		// tie keeps the earlier candidate
		add_row(mk(64'hA5A5_A5A5_A5A5_A5A5, 64'hA5A5_A5A5_A5A5_A5A5, 1, 1, 1, 1, 0), 1'b0, '0);
		add_row(mk(64'h0123_4567_89AB_CDEF, 64'h0123_4567_89AB_CDEF, 2, 2, 2, 1, 1),
			1'b1, rs(1, 1, 1, 0));
		// top lane alone
		add_row(mk(64'h8000_0000_0000_0000, '0, 0, 0, 0, 1, 1), 1'b1, rs(0, 0, 0, 128));
		// tag comes from the closing group; search end without candidate end is ignored
		add_row(mk(64'h0102_0304_0506_0708, '0, 3, 3, 3, 0, 1), 1'b0, '0);
		add_row(mk(64'h1020_3040_5060_7080, 64'h2010_4030_6050_8070, -1, -1, -1, 0, 0), 1'b0, '0);
		add_row(mk(64'hFF00_FF00_FF00_FF00, 64'h00FF_00FF_00FF_00FF, -2, 0, 4, 1, 0), 1'b0, '0);
		// smaller later candidate replaces, larger one does not
		add_row(mk(64'h0000_0000_0000_0010, '0, 4, -4, 0, 1, 0), 1'b0, '0);
		add_row(mk(64'h1111_1111_1111_1111, '0, -3, 3, 1, 1, 1), 1'b0, '0);
		// stray search end on a middle group, then a real one
		add_row(mk(64'h7F7F_7F7F_7F7F_7F7F, 64'h8080_8080_8080_8080, 5, 6, -7, 0, 1), 1'b0, '0);
		add_row(mk(64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0, -5, -6, 6, 1, 1), 1'b0, '0);
		// two candidates where the second is strictly smaller by one
		add_row(mk(64'h0000_0000_0000_0002, '0, 1, 2, 3, 1, 0), 1'b0, '0);
		add_row(mk(64'h0000_0000_0000_0001, '0, -1, -2, -3, 1, 1), 1'b0, '0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].res);

		// random searches, with one stretch free of idling on both sides
		base = sent;
		while (sent - base < RAND_ITEMS) begin
			idle_en = !((sent - base) >= QUIET_FROM && (sent - base) < QUIET_TO);
			random_search();
		end
		idle_en = 1'b1;

		// running sum saturates, so the reported sum saturates as well
		long_search(1030);

		item_valid <= 1'b0;
		while (best_match_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
rtl/bms_pkg.sv
rtl/bms_lane.sv
rtl/bms_accum.sv
rtl/block_match_sad_search.sv
bench/tb_top.sv
